FILE: sv/res_pkg.sv
package res_pkg;

	// defaults for the top level parameters
	localparam int MAX_RECORDS_DEF = 16;
	localparam int KEY_CHARS_DEF   = 8;

	// field widths fixed by the interface
	localparam int KEY_W  = 64;
	localparam int AGE_W  = 8;
	localparam int MODE_W = 3;

	// sort_mode decoding: bit 0 is the direction, bits 2:1 select the key
	localparam logic [1:0] FIELD_ID   = 2'd0;
	localparam logic [1:0] FIELD_NAME = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MAX = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_RD_I,
		ST_HOLD_I,
		ST_RD_J,
		ST_CMP,
		ST_WB,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_en;   // write the incoming record
		logic rd_en;     // read the store into the read register
		logic hold_load; // copy the read register into the hold register
		logic cmp_en;    // compare hold against read, swap if out of order
		logic wb_en;     // write the hold register back
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic sort_en;
	} stat_t;

endpackage

FILE: sv/res_datapath.sv
module res_datapath import res_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int KEY_CHARS   = KEY_CHARS_DEF,
	parameter int IDX_W       = $clog2(MAX_RECORDS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MODE_W-1:0] cfg_wr_data,
	input  cmd_t              cmd,
	input  logic [IDX_W-1:0]  addr,
	input  logic [KEY_W-1:0]  id_key,
	input  logic [KEY_W-1:0]  name_key,
	input  logic [AGE_W-1:0]  age,
	output stat_t             stat,
	output logic [KEY_W-1:0]  out_id_key,
	output logic [KEY_W-1:0]  out_name_key,
	output logic [AGE_W-1:0]  out_age
);

	localparam int KEY_BITS = 8 * KEY_CHARS;
	localparam int PAD_BITS = KEY_W - KEY_BITS;

	logic [MODE_W-1:0]   mode_q;
	logic [KEY_BITS-1:0] id_mem   [MAX_RECORDS];
	logic [KEY_BITS-1:0] name_mem [MAX_RECORDS];
	logic [AGE_W-1:0]    age_mem  [MAX_RECORDS];

	logic [KEY_BITS-1:0] rd_id_q, rd_name_q, hold_id_q, hold_name_q;
	logic [AGE_W-1:0]    rd_age_q, hold_age_q;

	logic [KEY_BITS-1:0] key_hold, key_rd;
	logic                swap;
	logic                we;
	logic [KEY_BITS-1:0] wr_id, wr_name;
	logic [AGE_W-1:0]    wr_age;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// sort key select, age zero extended to the key width
	always_comb begin
		unique case (mode_q[2:1])
			FIELD_ID: begin
				key_hold = hold_id_q;
				key_rd   = rd_id_q;
			end
			FIELD_NAME: begin
				key_hold = hold_name_q;
				key_rd   = rd_name_q;
			end
			default: begin
				key_hold = KEY_BITS'(hold_age_q);
				key_rd   = KEY_BITS'(rd_age_q);
			end
		endcase
	end

	assign swap = mode_q[0] ? (key_hold < key_rd) : (key_hold > key_rd);
	assign stat.sort_en = (mode_q <= MODE_MAX);

	assign we = cmd.load_en | cmd.wb_en | (cmd.cmp_en & swap);

	always_comb begin
		if (cmd.load_en) begin
			wr_id   = id_key[KEY_W-1 -: KEY_BITS];
			wr_name = name_key[KEY_W-1 -: KEY_BITS];
			wr_age  = age;
		end else begin
			wr_id   = hold_id_q;
			wr_name = hold_name_q;
			wr_age  = hold_age_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[addr]   <= wr_id;
			name_mem[addr] <= wr_name;
			age_mem[addr]  <= wr_age;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_id_q   <= id_mem[addr];
			rd_name_q <= name_mem[addr];
			rd_age_q  <= age_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_load || (cmd.cmp_en && swap)) begin
			hold_id_q   <= rd_id_q;
			hold_name_q <= rd_name_q;
			hold_age_q  <= rd_age_q;
		end
	end

	assign out_id_key   = KEY_W'(rd_id_q) << PAD_BITS;
	assign out_name_key = KEY_W'(rd_name_q) << PAD_BITS;
	assign out_age      = rd_age_q;

endmodule

FILE: sv/res_ctrl.sv
module res_ctrl import res_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int IDX_W       = $clog2(MAX_RECORDS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_last,
	output logic             truncated,
	input  stat_t            stat,
	output cmd_t             cmd,
	output logic [IDX_W-1:0] addr
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RECORDS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
	localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic [CNT_W-1:0]  count_m1;
	logic [IDX_W-1:0]  last_idx;
	logic              full;
	logic              in_fire, out_fire;

	assign count_m1 = count_q - CNT_ONE;
	assign last_idx = count_m1[IDX_W-1:0];
	assign full     = (count_q == CNT_FULL);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_fire && last) state_d = ST_START;
			ST_START: begin
				if (stat.sort_en && count_q >= CNT_TWO) state_d = ST_RD_I;
				else state_d = ST_EMIT_RD;
			end
			ST_RD_I:    state_d = ST_HOLD_I;
			ST_HOLD_I:  state_d = ST_RD_J;
			ST_RD_J:    state_d = ST_CMP;
			ST_CMP:     state_d = (j_q == last_idx) ? ST_WB : ST_RD_J;
			ST_WB:      state_d = ((i_q + IDX_ONE) == last_idx) ? ST_EMIT_RD : ST_RD_I;
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_fire) state_d = (k_q == last_idx) ? ST_IDLE : ST_EMIT_RD;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		addr     = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_en = in_valid && !full;
				addr        = count_q[IDX_W-1:0];
			end
			ST_RD_I: begin
				cmd.rd_en = 1'b1;
				addr      = i_q;
			end
			ST_HOLD_I: cmd.hold_load = 1'b1;
			ST_RD_J: begin
				cmd.rd_en = 1'b1;
				addr      = j_q;
			end
			ST_CMP: begin
				cmd.cmp_en = 1'b1;
				addr       = j_q;
			end
			ST_WB: begin
				cmd.wb_en = 1'b1;
				addr      = i_q;
			end
			ST_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				addr      = k_q;
			end
			ST_EMIT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	assign out_last  = (k_q == last_idx);
	assign truncated = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					k_q <= '0;
					if (in_fire) begin
						if (full) ovf_q <= 1'b1;
						else count_q <= count_q + CNT_ONE;
					end
				end
				ST_HOLD_I: j_q <= i_q + IDX_ONE;
				ST_CMP:    j_q <= j_q + IDX_ONE;
				ST_WB:     i_q <= i_q + IDX_ONE;
				ST_EMIT: begin
					if (out_fire) begin
						k_q <= k_q + IDX_ONE;
						if (k_q == last_idx) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("record count beyond capacity");

	a_sort_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD_I |-> count_q >= CNT_TWO)
		else $error("sort pass started with fewer than two records");

	a_inner_above_outer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> (j_q > i_q && j_q <= last_idx))
		else $error("inner index out of range");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> k_q <= last_idx)
		else $error("emit index beyond stored records");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_last |=> (count_q == '0 && !ovf_q && in_ready))
		else $error("run state not cleared after last transfer");

endmodule

FILE: sv/record_exchange_sorter.sv
// sequence: records are loaded while idle; after the last, a start state, then
//   the sort passes for n stored records (none for sort_mode 6 or 7 or n < 2),
//   then a read state and an emit state per emitted record, the emit state held while out_ready is low
// runs: one at a time, no new record is taken until the last sorted record is sent,
//   set by the single read and single write port of the record store
// reset: clears sequencer, record count, truncation flag and sort_mode, not the store
module record_exchange_sorter import res_pkg::*; #(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int KEY_CHARS   = KEY_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration: sort_mode register
	input  logic              cfg_wr_en,
	input  logic [MODE_W-1:0] cfg_wr_data,
	// input records
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KEY_W-1:0]  id_key,
	input  logic [KEY_W-1:0]  name_key,
	input  logic [AGE_W-1:0]  age,
	input  logic              last,
	// sorted records
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KEY_W-1:0]  out_id_key,
	output logic [KEY_W-1:0]  out_name_key,
	output logic [AGE_W-1:0]  out_age,
	output logic              out_last,
	output logic              truncated
);

	localparam int IDX_W = $clog2(MAX_RECORDS);

	// controller to datapath
	cmd_t             cmd;
	stat_t            stat;
	logic [IDX_W-1:0] addr;

	// sequencer: load, sort passes and emission
	// each input transfer writes one record until the store is full, then
	// sets the truncation flag; a last record starts the sort either way
	// outer index i holds one record in the hold register while the inner
	// index j sweeps the rest, each compare takes a read state and a compare state
	res_ctrl #(
		.MAX_RECORDS (MAX_RECORDS),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_last  (out_last),
		.truncated (truncated),
		.stat      (stat),
		.cmd       (cmd),
		.addr      (addr)
	);

	// record store, hold and read registers, key compare
	// keys are stored in their top KEY_CHARS bytes and zero padded on output
	// the read register doubles as the output register while a transfer waits
	res_datapath #(
		.MAX_RECORDS (MAX_RECORDS),
		.KEY_CHARS   (KEY_CHARS),
		.IDX_W       (IDX_W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.addr         (addr),
		.id_key       (id_key),
		.name_key     (name_key),
		.age          (age),
		.stat         (stat),
		.out_id_key   (out_id_key),
		.out_name_key (out_name_key),
		.out_age      (out_age)
	);

endmodule
